/* design/eopg_pkg.sv */
// Package for the elliptical orbit phase generator.
// Holds the register map, field widths and the quarter-wave table generator.
// No dependencies.
package eopg_pkg;

   // Configuration register map
   localparam int unsigned CSR_INDEX_BITS = 4;
   localparam int unsigned CSR_DATA_BITS  = 32;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPIN_RATE    = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ORBIT_RATE   = 4'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ORBIT_ENABLE = 4'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RADIUS_X     = 4'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RADIUS_Y     = 4'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CENTER_X     = 4'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CENTER_Y     = 4'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_PHASE  = 4'd7;

   // Field widths
   localparam int unsigned RATE_BITS    = 25;
   localparam int unsigned RADIUS_BITS  = 11;
   localparam int unsigned POS_BITS     = 16;
   localparam int unsigned HEADING_BITS = 24;
   localparam int unsigned ELAPSED_BITS = 16;
   localparam int unsigned SINE_BITS    = 17;  // signed table value after folding
   localparam int unsigned MAG_BITS     = 15;  // table magnitude, 0..32767

   // Shared multiplier operand and product widths
   localparam int unsigned MUL_A_BITS = RATE_BITS;
   localparam int unsigned MUL_B_BITS = SINE_BITS;
   localparam int unsigned PROD_BITS  = MUL_A_BITS + MUL_B_BITS;

   // Table generation constants (Q30)
   localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] DENS [9] = '{64'd342, 64'd272, 64'd210, 64'd156, 64'd110,
                                        64'd72, 64'd42, 64'd20, 64'd6};

   // One quarter-wave entry: round(32767 * sin(pi/2 * k / 2^table_bits)),
   // via a nested series in Q30. Evaluated at elaboration only.
   function automatic logic [15:0] sine_entry(input int unsigned k,
                                              input int unsigned table_bits);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] r;
      x  = (64'(k) * HALF_PI_Q30) >> table_bits;
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      for (int j = 0; j < 9; j++) begin
         t = Q30_ONE - (((x2 * t) >> 30) / DENS[j]);
      end
      s = (x * t) >> 30;
      r = (s * 64'd32767 + (Q30_ONE >> 1)) >> 30;
      return r[15:0];
   endfunction

endpackage

/* design/eopg_sine_unit.sv */
// Quarter-wave sine lookup with quadrant folding and registered read.
// Depends on eopg_pkg for the table generator and widths.
module eopg_sine_unit #(
   parameter int TABLE_BITS = 10
) (
   input  logic                                  clock,
   input  logic [TABLE_BITS+1:0]                 phase_idx,
   output logic signed [eopg_pkg::SINE_BITS-1:0] sine
);

   localparam int TBL_N = 1 << TABLE_BITS;

   typedef logic [eopg_pkg::MAG_BITS-1:0] rom_type [0:TBL_N];

   function automatic rom_type build_rom();
      rom_type     r;
      logic [15:0] v;
      for (int k = 0; k <= TBL_N; k++) begin
         v    = eopg_pkg::sine_entry(k, TABLE_BITS);
         r[k] = v[eopg_pkg::MAG_BITS-1:0];
      end
      return r;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   logic [1:0]                       quad;
   logic [TABLE_BITS-1:0]            frac;
   logic [TABLE_BITS:0]              addr;
   logic [eopg_pkg::MAG_BITS-1:0]    mag_ff;
   logic                             neg_ff;
   logic signed [eopg_pkg::SINE_BITS-1:0] mag_s;

   // Odd quadrants read the table backwards
   assign quad = phase_idx[TABLE_BITS+1:TABLE_BITS];
   assign frac = phase_idx[TABLE_BITS-1:0];
   assign addr = quad[0] ? ((TABLE_BITS+1)'(TBL_N) - {1'b0, frac}) : {1'b0, frac};

   // Registered table read
   always_ff @(posedge clock) begin
      mag_ff <= SINE_ROM[addr];
      neg_ff <= quad[1];
   end

   // Lower half of the turn is negative
   assign mag_s = $signed({{(eopg_pkg::SINE_BITS-eopg_pkg::MAG_BITS){1'b0}}, mag_ff});
   assign sine  = neg_ff ? -mag_s : mag_s;

endmodule

/* design/elliptical_orbit_phase_generator.sv */
// Top level of the elliptical orbit phase generator.
// Depends on eopg_pkg and eopg_sine_unit.
//
// Each accepted item is one time step: unless it is frozen, the spin and orbit
// phase accumulators advance by rate * elapsed / 2^16 (rounded down; orbit only
// with orbiting on), and one result gives the position on the ellipse (or
// center + radius with orbiting off) and the spin heading. An item is taken
// only in idle, once the last one has reached the output register, which waits
// for a previous result still held there; req_ready is high only between items.
// A sequencer runs four products through one shared 25x17 multiplier and two
// lookups through one registered sine table. A finished result sits in the
// output register while the next item is taken.
// Configuration writes are taken at any time (csr_ready is always high).
module elliptical_orbit_phase_generator #(
   parameter int PHASE_BITS = 24,
   parameter int TABLE_BITS = 10
) (
   input  logic                                        clock,
   input  logic                                        reset,
   // input items
   input  logic                                        req_valid,
   output logic                                        req_ready,
   input  logic [eopg_pkg::ELAPSED_BITS-1:0]           req_elapsed,
   input  logic                                        req_frozen,
   input  logic                                        req_restart,
   // results
   output logic                                        rsp_valid,
   input  logic                                        rsp_ready,
   output logic signed [eopg_pkg::POS_BITS-1:0]        rsp_pos_x,
   output logic signed [eopg_pkg::POS_BITS-1:0]        rsp_pos_y,
   output logic [eopg_pkg::HEADING_BITS-1:0]           rsp_heading,
   // configuration writes
   input  logic                                        csr_valid,
   output logic                                        csr_ready,
   input  logic [eopg_pkg::CSR_INDEX_BITS-1:0]         csr_index,
   input  logic [eopg_pkg::CSR_DATA_BITS-1:0]          csr_data
);

   localparam int IDX_BITS = TABLE_BITS + 2;
   localparam int POS_BITS = eopg_pkg::POS_BITS;
   localparam int SUM_BITS = POS_BITS + 2;

   // Sequencer codes
   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_SPIN_MUL = 4'd1;
   localparam logic [3:0] ST_SPIN_ADD = 4'd2;
   localparam logic [3:0] ST_ORB_MUL  = 4'd3;
   localparam logic [3:0] ST_ORB_ADD  = 4'd4;
   localparam logic [3:0] ST_COS_ADDR = 4'd5;
   localparam logic [3:0] ST_COS_MUL  = 4'd6;
   localparam logic [3:0] ST_SIN_MUL  = 4'd7;
   localparam logic [3:0] ST_SIN_ADD  = 4'd8;

   localparam logic [PHASE_BITS-1:0] QUARTER = PHASE_BITS'(1) << (PHASE_BITS - 2);

   // Configuration registers
   logic signed [eopg_pkg::RATE_BITS-1:0]   spin_rate_ff;
   logic signed [eopg_pkg::RATE_BITS-1:0]   orbit_rate_ff;
   logic                                    orbit_enable_ff;
   logic signed [eopg_pkg::RADIUS_BITS-1:0] radius_x_ff;
   logic signed [eopg_pkg::RADIUS_BITS-1:0] radius_y_ff;
   logic signed [POS_BITS-1:0]              center_x_ff;
   logic signed [POS_BITS-1:0]              center_y_ff;
   logic [eopg_pkg::HEADING_BITS-1:0]       start_phase_ff;

   // Working state
   logic [3:0]                              state_ff, state_in;
   logic [PHASE_BITS-1:0]                   spin_phase_ff, spin_phase_in;
   logic [PHASE_BITS-1:0]                   orbit_phase_ff, orbit_phase_in;
   logic [eopg_pkg::ELAPSED_BITS-1:0]       elapsed_ff;
   logic                                    frozen_ff;
   logic                                    restart_ff;
   logic signed [eopg_pkg::PROD_BITS-1:0]   prod_ff;
   logic signed [POS_BITS-1:0]              pos_x_ff;
   logic                                    rsp_valid_ff;
   logic signed [POS_BITS-1:0]              rsp_pos_x_ff;
   logic signed [POS_BITS-1:0]              rsp_pos_y_ff;
   logic [eopg_pkg::HEADING_BITS-1:0]       rsp_heading_ff;

   // Datapath nets
   logic signed [eopg_pkg::MUL_A_BITS-1:0]  mul_a;
   logic signed [eopg_pkg::MUL_B_BITS-1:0]  mul_b;
   logic signed [eopg_pkg::PROD_BITS-1:0]   prod_shr16;
   logic signed [eopg_pkg::PROD_BITS-1:0]   prod_shr15;
   logic [PHASE_BITS-1:0]                   delta;
   logic [PHASE_BITS-1:0]                   phase_sel;
   logic [IDX_BITS-1:0]                     phase_idx;
   logic signed [eopg_pkg::SINE_BITS-1:0]   sine;
   logic [PHASE_BITS-1:0]                   start_scaled;
   logic [eopg_pkg::HEADING_BITS-1:0]       heading;
   logic signed [SUM_BITS-1:0]              term_x, term_y;
   logic signed [POS_BITS-1:0]              sat_x, sat_y;
   logic                                    out_free;

   function automatic logic signed [POS_BITS-1:0] sat_add(
      input logic signed [POS_BITS-1:0] c,
      input logic signed [SUM_BITS-1:0] t
   );
      logic signed [SUM_BITS-1:0] s;
      s = {{2{c[POS_BITS-1]}}, c} + t;
      if (s > SUM_BITS'(32767)) begin
         return 16'sh7FFF;
      end else if (s < -SUM_BITS'(32768)) begin
         return 16'sh8000;
      end
      return s[POS_BITS-1:0];
   endfunction

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         spin_rate_ff    <= '0;
         orbit_rate_ff   <= '0;
         orbit_enable_ff <= 1'b0;
         radius_x_ff     <= '0;
         radius_y_ff     <= '0;
         center_x_ff     <= '0;
         center_y_ff     <= '0;
         start_phase_ff  <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            eopg_pkg::CSR_SPIN_RATE:    spin_rate_ff    <= csr_data[eopg_pkg::RATE_BITS-1:0];
            eopg_pkg::CSR_ORBIT_RATE:   orbit_rate_ff   <= csr_data[eopg_pkg::RATE_BITS-1:0];
            eopg_pkg::CSR_ORBIT_ENABLE: orbit_enable_ff <= csr_data[0];
            eopg_pkg::CSR_RADIUS_X:     radius_x_ff <= csr_data[eopg_pkg::RADIUS_BITS-1:0];
            eopg_pkg::CSR_RADIUS_Y:     radius_y_ff <= csr_data[eopg_pkg::RADIUS_BITS-1:0];
            eopg_pkg::CSR_CENTER_X:     center_x_ff     <= csr_data[POS_BITS-1:0];
            eopg_pkg::CSR_CENTER_Y:     center_y_ff     <= csr_data[POS_BITS-1:0];
            eopg_pkg::CSR_START_PHASE:
               start_phase_ff <= csr_data[eopg_pkg::HEADING_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Width conversions between the phase and the 24-bit fields / table index
   generate
      if (PHASE_BITS >= eopg_pkg::HEADING_BITS) begin : g_wide_phase
         assign heading = spin_phase_ff[PHASE_BITS-1 -: eopg_pkg::HEADING_BITS];
         assign start_scaled = {start_phase_ff,
                                {(PHASE_BITS-eopg_pkg::HEADING_BITS){1'b0}}};
      end else begin : g_narrow_phase
         assign heading = {spin_phase_ff, {(eopg_pkg::HEADING_BITS-PHASE_BITS){1'b0}}};
         assign start_scaled = start_phase_ff[eopg_pkg::HEADING_BITS-1 -: PHASE_BITS];
      end
      if (PHASE_BITS >= IDX_BITS) begin : g_idx_trunc
         assign phase_idx = phase_sel[PHASE_BITS-1 -: IDX_BITS];
      end else begin : g_idx_pad
         assign phase_idx = {phase_sel, {(IDX_BITS-PHASE_BITS){1'b0}}};
      end
   endgenerate

   // Table lookup: cosine is the sine a quarter turn on
   assign phase_sel = (state_ff == ST_COS_ADDR) ? (orbit_phase_ff + QUARTER) : orbit_phase_ff;

   eopg_sine_unit #(
      .TABLE_BITS (TABLE_BITS)
   ) u_sine (
      .clock     (clock),
      .phase_idx (phase_idx),
      .sine      (sine)
   );

   // Shared multiplier operand selection; the y product is kept while the
   // final step waits for the output register
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_SPIN_MUL: begin
            mul_a = spin_rate_ff;
            mul_b = $signed({1'b0, elapsed_ff});
         end
         ST_ORB_MUL: begin
            mul_a = orbit_rate_ff;
            mul_b = $signed({1'b0, elapsed_ff});
         end
         ST_COS_MUL: begin
            mul_a = eopg_pkg::MUL_A_BITS'(radius_x_ff);
            mul_b = sine;
         end
         ST_SIN_MUL, ST_SIN_ADD: begin
            mul_a = eopg_pkg::MUL_A_BITS'(radius_y_ff);
            mul_b = sine;
         end
         default: ;
      endcase
   end

   // Floor division by 2^16 (phase step) and 2^15 (radius scaling)
   assign prod_shr16 = prod_ff >>> 16;
   assign prod_shr15 = prod_ff >>> 15;
   assign delta      = prod_shr16[PHASE_BITS-1:0];

   assign term_x = orbit_enable_ff ? prod_shr15[SUM_BITS-1:0] : SUM_BITS'(radius_x_ff);
   assign term_y = orbit_enable_ff ? prod_shr15[SUM_BITS-1:0] : SUM_BITS'(radius_y_ff);
   assign sat_x  = sat_add(center_x_ff, term_x);
   assign sat_y  = sat_add(center_y_ff, term_y);

   // Sequencer next state and phase updates
   always_comb begin
      state_in       = state_ff;
      spin_phase_in  = spin_phase_ff;
      orbit_phase_in = orbit_phase_ff;
      case (state_ff)
         ST_IDLE:     if (req_valid) state_in = ST_SPIN_MUL;
         ST_SPIN_MUL: state_in = ST_SPIN_ADD;
         ST_SPIN_ADD: begin
            if (!frozen_ff) begin
               spin_phase_in = spin_phase_ff + delta;
               if (restart_ff) orbit_phase_in = start_scaled;
            end
            state_in = ST_ORB_MUL;
         end
         ST_ORB_MUL:  state_in = ST_ORB_ADD;
         ST_ORB_ADD: begin
            if (!frozen_ff && orbit_enable_ff) orbit_phase_in = orbit_phase_ff + delta;
            state_in = ST_COS_ADDR;
         end
         ST_COS_ADDR: state_in = ST_COS_MUL;
         ST_COS_MUL:  state_in = ST_SIN_MUL;
         ST_SIN_MUL:  state_in = ST_SIN_ADD;
         ST_SIN_ADD:  if (out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Control and phase registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         spin_phase_ff  <= '0;
         orbit_phase_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         spin_phase_ff  <= spin_phase_in;
         orbit_phase_ff <= orbit_phase_in;
         if (state_ff == ST_SIN_ADD && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         elapsed_ff <= req_elapsed;
         frozen_ff  <= req_frozen;
         restart_ff <= req_restart;
      end
      prod_ff <= mul_a * mul_b;
      if (state_ff == ST_SIN_MUL) pos_x_ff <= sat_x;
      if (state_ff == ST_SIN_ADD && out_free) begin
         rsp_pos_x_ff   <= pos_x_ff;
         rsp_pos_y_ff   <= sat_y;
         rsp_heading_ff <= heading;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_pos_x   = rsp_pos_x_ff;
   assign rsp_pos_y   = rsp_pos_y_ff;
   assign rsp_heading = rsp_heading_ff;

   // Checks
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_SPIN_MUL))
      else $error("accepted item did not start the sequence");

   a_frozen_spin: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SPIN_ADD && frozen_ff) |=> $stable(spin_phase_ff))
      else $error("frozen item changed spin phase");

   a_orbit_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_SPIN_ADD && state_ff != ST_ORB_ADD) |=> $stable(orbit_phase_ff))
      else $error("orbit phase changed outside its update steps");

   a_orbit_disabled: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ORB_ADD && !orbit_enable_ff) |=> $stable(orbit_phase_ff))
      else $error("orbit phase advanced while orbiting is off");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_SIN_ADD))
      else $error("result raised outside the final step");

endmodule

/* verif/elliptical_orbit_phase_generator_tb.sv */
// Testbench for elliptical_orbit_phase_generator: directed table then random steps, each result
// checked against a typed value where a row gives one, else an in-bench model of the phase
// accumulators and sine table. Depends on eopg_pkg and the block's RTL.
module elliptical_orbit_phase_generator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PHASE_W         = 24;
   localparam int LUT_BITS        = 10;
   localparam int LUT_LAST        = 1 << LUT_BITS;
   localparam int SETTLE_CYCLES   = 14;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int RANDOM_PHASES   = 7;
   localparam int PHASE_ITEMS     = 250;

   localparam int IDX_W  = eopg_pkg::CSR_INDEX_BITS;
   localparam int DATA_W = eopg_pkg::CSR_DATA_BITS;
   localparam int POS_W  = eopg_pkg::POS_BITS;
   localparam int HEAD_W = eopg_pkg::HEADING_BITS;
   localparam int EL_W   = eopg_pkg::ELAPSED_BITS;
   localparam int RATE_W = eopg_pkg::RATE_BITS;
   localparam int RAD_W  = eopg_pkg::RADIUS_BITS;

   // index with no register behind it
   localparam logic [IDX_W-1:0] CSR_UNUSED = 4'd15;

   // quarter-wave series constants (Q30)
   localparam logic [63:0] LUT_ONE     = 64'd1 << 30;
   localparam logic [63:0] LUT_HALF_PI = 64'd1686629713;
   localparam logic [63:0] LUT_DIVS [9] = '{64'd342, 64'd272, 64'd210, 64'd156, 64'd110,
                                            64'd72, 64'd42, 64'd20, 64'd6};

   typedef enum logic {ROW_WRITE, ROW_STEP} row_kind_type;

   typedef struct packed {
      logic [POS_W-1:0]  pos_x;
      logic [POS_W-1:0]  pos_y;
      logic [HEAD_W-1:0] heading;
   } orbit_result_type;

   typedef struct {
      bit               typed;
      orbit_result_type value;
   } known_entry_type;

   typedef struct {
      row_kind_type        kind;
      logic [IDX_W-1:0]    idx;
      logic [DATA_W-1:0]   data;
      logic [EL_W-1:0]     elapsed;
      bit                  frozen;
      bit                  restart;
      bit                  typed;
      orbit_result_type    value;
   } stim_row_type;

   typedef struct {
      logic [31:0] spin_rate, orbit_rate, orbit_enable, radius_x;
      logic [31:0] radius_y, center_x, center_y, start_phase;
   } orbit_settings_type;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic [EL_W-1:0]           req_elapsed;
   logic                      req_frozen;
   logic                      req_restart;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic signed [POS_W-1:0]   rsp_pos_x;
   logic signed [POS_W-1:0]   rsp_pos_y;
   logic [HEAD_W-1:0]         rsp_heading;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [IDX_W-1:0]          csr_index;
   logic [DATA_W-1:0]         csr_data;

   // mirror of the registers and the two accumulators
   logic signed [RATE_W-1:0]  set_spin_rate   = '0;
   logic signed [RATE_W-1:0]  set_orbit_rate  = '0;
   logic                      set_orbit_en    = 1'b0;
   logic signed [RAD_W-1:0]   set_radius_x    = '0;
   logic signed [RAD_W-1:0]   set_radius_y    = '0;
   logic signed [POS_W-1:0]   set_center_x    = '0;
   logic signed [POS_W-1:0]   set_center_y    = '0;
   logic [PHASE_W-1:0]        set_start_phase = '0;
   logic [PHASE_W-1:0]        spin_ph         = '0;
   logic [PHASE_W-1:0]        orbit_ph        = '0;

   int sine_lut [0:LUT_LAST];

   orbit_result_type pending_positions [$];
   known_entry_type  known_results [$];

   int  error_count     = 0;
   int  steps_sent      = 0;
   int  results_checked = 0;
   int  settings_loaded = 0;
   bit  no_idle         = 1'b0;
   bit  hold_off_wanted = 1'b0;

   elliptical_orbit_phase_generator #(
      .PHASE_BITS(PHASE_W),
      .TABLE_BITS(LUT_BITS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_elapsed(req_elapsed),
      .req_frozen (req_frozen),
      .req_restart(req_restart),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_pos_x  (rsp_pos_x),
      .rsp_pos_y  (rsp_pos_y),
      .rsp_heading(rsp_heading),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------- model

   // one quarter-wave entry, nested series in Q30
   function automatic int lut_entry(int k);
      logic [63:0] x, x2, t, s;
      x  = (64'(k) * LUT_HALF_PI) >> LUT_BITS;
      x2 = (x * x) >> 30;
      t  = LUT_ONE;
      for (int j = 0; j < 9; j++) t = LUT_ONE - (((x2 * t) >> 30) / LUT_DIVS[j]);
      s = (x * t) >> 30;
      return int'((s * 64'd32767 + (LUT_ONE >> 1)) >> 30);
   endfunction

   initial begin
      for (int k = 0; k <= LUT_LAST; k++) sine_lut[k] = lut_entry(k);
   end

   // top bits of the phase pick quadrant and entry; odd quadrants run backwards
   function automatic int folded_sine(logic [PHASE_W-1:0] ph);
      logic [LUT_BITS+1:0] t;
      int v;
      t = ph[PHASE_W-1 -: LUT_BITS+2];
      v = t[LUT_BITS] ? sine_lut[LUT_LAST - int'(t[LUT_BITS-1:0])]
                      : sine_lut[t[LUT_BITS-1:0]];
      return t[LUT_BITS+1] ? -v : v;
   endfunction

   function automatic logic [POS_W-1:0] clamp16(longint v);
      if (v > 32767) return 16'h7FFF;
      if (v < -32768) return 16'h8000;
      return 16'(v);
   endfunction

   // advance the accumulators for one step and form its result
   function automatic orbit_result_type advance_orbit(logic [EL_W-1:0] el, bit fr, bit rs);
      orbit_result_type r;
      longint           c, s, px, py;
      if (!fr) begin
         spin_ph = spin_ph + PHASE_W'((longint'(set_spin_rate) * longint'(el)) >>> 16);
         if (rs) orbit_ph = set_start_phase;
         if (set_orbit_en)
            orbit_ph = orbit_ph + PHASE_W'((longint'(set_orbit_rate) * longint'(el)) >>> 16);
      end
      if (set_orbit_en) begin
         c  = longint'(folded_sine(orbit_ph + (PHASE_W'(1) << (PHASE_W - 2))));
         s  = longint'(folded_sine(orbit_ph));
         px = longint'(set_center_x) + ((longint'(set_radius_x) * c) >>> 15);
         py = longint'(set_center_y) + ((longint'(set_radius_y) * s) >>> 15);
      end else begin
         px = longint'(set_center_x) + longint'(set_radius_x);
         py = longint'(set_center_y) + longint'(set_radius_y);
      end
      r.pos_x   = clamp16(px);
      r.pos_y   = clamp16(py);
      r.heading = spin_ph;
      return r;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic flag_error(string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   always @(posedge clock) begin
      orbit_result_type want;
      known_entry_type  ke;
      if (!reset) begin
         // register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               eopg_pkg::CSR_SPIN_RATE:    set_spin_rate   = csr_data[RATE_W-1:0];
               eopg_pkg::CSR_ORBIT_RATE:   set_orbit_rate  = csr_data[RATE_W-1:0];
               eopg_pkg::CSR_ORBIT_ENABLE: set_orbit_en    = csr_data[0];
               eopg_pkg::CSR_RADIUS_X:     set_radius_x    = csr_data[RAD_W-1:0];
               eopg_pkg::CSR_RADIUS_Y:     set_radius_y    = csr_data[RAD_W-1:0];
               eopg_pkg::CSR_CENTER_X:     set_center_x    = csr_data[POS_W-1:0];
               eopg_pkg::CSR_CENTER_Y:     set_center_y    = csr_data[POS_W-1:0];
               eopg_pkg::CSR_START_PHASE:  set_start_phase = csr_data[PHASE_W-1:0];
               default: ;
            endcase
         end
         // results against the oldest outstanding step
         if (rsp_valid && rsp_ready) begin
            if (pending_positions.size() == 0) begin
               flag_error("result with no step outstanding");
            end else begin
               want = pending_positions.pop_front();
               if (rsp_pos_x !== want.pos_x)
                  flag_error($sformatf("pos_x %0d, want %0d", rsp_pos_x, $signed(want.pos_x)));
               if (rsp_pos_y !== want.pos_y)
                  flag_error($sformatf("pos_y %0d, want %0d", rsp_pos_y, $signed(want.pos_y)));
               if (rsp_heading !== want.heading)
                  flag_error($sformatf("heading %06h, want %06h", rsp_heading, want.heading));
               results_checked++;
            end
         end
         // accepted step: run the model, a typed value overrides it
         if (req_valid && req_ready) begin
            want = advance_orbit(req_elapsed, req_frozen, req_restart);
            if (known_results.size() != 0) begin
               ke = known_results.pop_front();
               if (ke.typed) want = ke.value;
            end
            pending_positions.push_back(want);
            steps_sent++;
         end
      end
   end

   // ---------------------------------------------------------------- drivers

   function automatic int draw_gap();
      return no_idle ? 0 : $urandom_range(0, 10);
   endfunction

   // receiver: random stalls, one long hold-off on request
   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = draw_gap();
         if (hold_off_wanted) begin
            hold_off_wanted = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_valid && rsp_ready)) @(posedge clock);
      end
   end

   task automatic send_step(logic [EL_W-1:0] el, bit fr, bit rs,
                            bit typed, orbit_result_type value);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      known_results.push_back('{typed, value});
      req_valid   <= 1'b1;
      req_elapsed <= el;
      req_frozen  <= fr;
      req_restart <= rs;
      @(posedge clock);
      while (!(req_valid && req_ready)) @(posedge clock);
   endtask

   // stop offering and wait until every result is back and the block is quiet
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_positions.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= d;
      @(posedge clock);
      while (!(csr_valid && csr_ready)) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_settings(orbit_settings_type s);
      drain();
      write_reg(eopg_pkg::CSR_SPIN_RATE,    s.spin_rate);
      write_reg(eopg_pkg::CSR_ORBIT_RATE,   s.orbit_rate);
      write_reg(eopg_pkg::CSR_ORBIT_ENABLE, s.orbit_enable);
      write_reg(eopg_pkg::CSR_RADIUS_X,     s.radius_x);
      write_reg(eopg_pkg::CSR_RADIUS_Y,     s.radius_y);
      write_reg(eopg_pkg::CSR_CENTER_X,     s.center_x);
      write_reg(eopg_pkg::CSR_CENTER_Y,     s.center_y);
      write_reg(eopg_pkg::CSR_START_PHASE,  s.start_phase);
      settings_loaded++;
   endtask

   // extremes, values near zero or anything in range, sign extended to 32 bits
   function automatic logic [31:0] pick_value(int w, bit sgn);
      longint v;
      case ($urandom_range(0, 5))
         0:       v = sgn ? (longint'(1) << (w - 1)) - 1 : (longint'(1) << w) - 1;
         1:       v = sgn ? -(longint'(1) << (w - 1)) : 0;
         2:       v = longint'($urandom_range(0, 64)) - 32;
         default: v = longint'($urandom);
      endcase
      v = v & ((longint'(1) << w) - 1);
      if (sgn && v[w-1]) v = v - (longint'(1) << w);
      return 32'(v);
   endfunction

   function automatic orbit_settings_type random_settings();
      orbit_settings_type s;
      s.spin_rate    = pick_value(RATE_W, 1'b1);
      s.orbit_rate   = pick_value(RATE_W, 1'b1);
      s.orbit_enable = 32'($urandom_range(0, 3) != 0);
      s.radius_x     = pick_value(RAD_W, 1'b1);
      s.radius_y     = pick_value(RAD_W, 1'b1);
      s.center_x     = pick_value(POS_W, 1'b1);
      s.center_y     = pick_value(POS_W, 1'b1);
      s.start_phase  = pick_value(PHASE_W, 1'b0);
      return s;
   endfunction

   function automatic stim_row_type write_row(logic [IDX_W-1:0] idx, logic [31:0] d);
      return '{ROW_WRITE, idx, d, '0, 1'b0, 1'b0, 1'b0, '0};
   endfunction

   function automatic stim_row_type step_row(logic [EL_W-1:0] el, bit fr, bit rs);
      return '{ROW_STEP, CSR_UNUSED, '0, el, fr, rs, 1'b0, '0};
   endfunction

   function automatic stim_row_type known_row(logic [EL_W-1:0] el, bit fr, bit rs,
                                              logic [15:0] px, logic [15:0] py,
                                              logic [23:0] hd);
      return '{ROW_STEP, CSR_UNUSED, '0, el, fr, rs, 1'b1, '{px, py, hd}};
   endfunction

   // ---------------------------------------------------------------- sequence

   initial begin
      stim_row_type       rows [$];
      orbit_settings_type s;
      logic [EL_W-1:0]    el;

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_elapsed = '0;
      req_frozen  = 1'b0;
      req_restart = 1'b0;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_data    = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // after reset everything is zero, even with a long step and a restart
      rows.push_back(known_row(16'h0000, 1'b0, 1'b0, 16'h0000, 16'h0000, 24'h000000));
      rows.push_back(known_row(16'hFFFF, 1'b0, 1'b1, 16'h0000, 16'h0000, 24'h000000));
      // fixed offset saturating high on x and low on y, then the other way round
      rows.push_back(write_row(eopg_pkg::CSR_CENTER_X, 32'h0000_7FFF));
      rows.push_back(write_row(eopg_pkg::CSR_RADIUS_X, 32'h0000_03FF));
      rows.push_back(write_row(eopg_pkg::CSR_CENTER_Y, 32'hFFFF_8000));
      rows.push_back(write_row(eopg_pkg::CSR_RADIUS_Y, 32'hFFFF_FC00));
      rows.push_back(known_row(16'h0000, 1'b0, 1'b0, 16'h7FFF, 16'h8000, 24'h000000));
      rows.push_back(write_row(eopg_pkg::CSR_CENTER_X, 32'hFFFF_8000));
      rows.push_back(write_row(eopg_pkg::CSR_RADIUS_X, 32'hFFFF_FC00));
      rows.push_back(write_row(eopg_pkg::CSR_CENTER_Y, 32'h0000_7FFF));
      rows.push_back(write_row(eopg_pkg::CSR_RADIUS_Y, 32'h0000_03FF));
      rows.push_back(known_row(16'h0000, 1'b0, 1'b0, 16'h8000, 16'h7FFF, 24'h000000));
      // spin at the largest rates both ways; a frozen step ignores its restart
      rows.push_back(write_row(eopg_pkg::CSR_SPIN_RATE, 32'h00FF_FFFF));
      rows.push_back(known_row(16'hFFFF, 1'b0, 1'b0, 16'h8000, 16'h7FFF, 24'hFFFEFF));
      rows.push_back(known_row(16'hFFFF, 1'b1, 1'b1, 16'h8000, 16'h7FFF, 24'hFFFEFF));
      rows.push_back(write_row(eopg_pkg::CSR_SPIN_RATE, 32'hFF00_0000));
      rows.push_back(known_row(16'hFFFF, 1'b0, 1'b0, 16'h8000, 16'h7FFF, 24'hFFFFFF));
      rows.push_back(step_row(16'h0001, 1'b0, 1'b0));
      // restart with the orbit off still loads the phase
      rows.push_back(write_row(eopg_pkg::CSR_START_PHASE, 32'h0040_0000));
      rows.push_back(step_row(16'h0000, 1'b0, 1'b1));
      rows.push_back(write_row(eopg_pkg::CSR_CENTER_X, 32'h0000_0000));
      rows.push_back(write_row(eopg_pkg::CSR_CENTER_Y, 32'h0000_0000));
      rows.push_back(write_row(eopg_pkg::CSR_RADIUS_X, 32'h0000_03FF));
      rows.push_back(write_row(eopg_pkg::CSR_RADIUS_Y, 32'h0000_03FF));
      rows.push_back(write_row(eopg_pkg::CSR_SPIN_RATE, 32'h0000_0000));
      rows.push_back(write_row(eopg_pkg::CSR_ORBIT_ENABLE, 32'h0000_0001));
      rows.push_back(step_row(16'h0000, 1'b0, 1'b0));
      // each quadrant boundary and the last phase value
      rows.push_back(write_row(eopg_pkg::CSR_START_PHASE, 32'h0080_0000));
      rows.push_back(step_row(16'h0000, 1'b0, 1'b1));
      rows.push_back(write_row(eopg_pkg::CSR_START_PHASE, 32'h00C0_0000));
      rows.push_back(step_row(16'h0000, 1'b0, 1'b1));
      rows.push_back(write_row(eopg_pkg::CSR_START_PHASE, 32'h00FF_FFFF));
      rows.push_back(step_row(16'h0000, 1'b0, 1'b1));
      // orbit at the extreme rates, wrapping forwards and backwards
      rows.push_back(write_row(eopg_pkg::CSR_ORBIT_RATE, 32'h00FF_FFFF));
      rows.push_back(step_row(16'hFFFF, 1'b0, 1'b0));
      rows.push_back(step_row(16'hFFFF, 1'b1, 1'b0));
      rows.push_back(write_row(eopg_pkg::CSR_ORBIT_RATE, 32'hFF00_0000));
      rows.push_back(write_row(eopg_pkg::CSR_RADIUS_X, 32'hFFFF_FC00));
      rows.push_back(write_row(eopg_pkg::CSR_RADIUS_Y, 32'hFFFF_FC00));
      rows.push_back(step_row(16'hFFFF, 1'b0, 1'b0));
      rows.push_back(step_row(16'h3039, 1'b0, 1'b0));
      rows.push_back(step_row(16'h0001, 1'b0, 1'b0));
      // a write to an index with no register changes nothing
      rows.push_back(write_row(CSR_UNUSED, 32'hFFFF_FFFF));
      rows.push_back(step_row(16'hFFFF, 1'b0, 1'b0));
      // restart while off, then show the loaded phase once orbiting again
      rows.push_back(write_row(eopg_pkg::CSR_ORBIT_ENABLE, 32'h0000_0000));
      rows.push_back(write_row(eopg_pkg::CSR_START_PHASE, 32'h0012_3456));
      rows.push_back(step_row(16'h0064, 1'b0, 1'b1));
      rows.push_back(write_row(eopg_pkg::CSR_ORBIT_ENABLE, 32'h0000_0001));
      rows.push_back(write_row(eopg_pkg::CSR_ORBIT_RATE, 32'h0000_0000));
      rows.push_back(step_row(16'h0000, 1'b0, 1'b0));
      // saturation while on the ellipse
      rows.push_back(write_row(eopg_pkg::CSR_CENTER_X, 32'h0000_7FFF));
      rows.push_back(write_row(eopg_pkg::CSR_CENTER_Y, 32'hFFFF_8000));
      rows.push_back(step_row(16'h0000, 1'b0, 1'b0));

      foreach (rows[n]) begin
         if (rows[n].kind == ROW_WRITE) begin
            drain();
            write_reg(rows[n].idx, rows[n].data);
         end else begin
            send_step(rows[n].elapsed, rows[n].frozen, rows[n].restart,
                      rows[n].typed, rows[n].value);
         end
      end

      // random phases: all-max, all-min, then random settings
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p == 0)
            s = '{32'h00FF_FFFF, 32'h00FF_FFFF, 32'h1, 32'h0000_03FF,
                  32'h0000_03FF, 32'h0000_7FFF, 32'h0000_7FFF, 32'h00FF_FFFF};
         else if (p == 1)
            s = '{32'hFF00_0000, 32'hFF00_0000, 32'h0, 32'hFFFF_FC00,
                  32'hFFFF_FC00, 32'hFFFF_8000, 32'hFFFF_8000, 32'h0};
         else
            s = random_settings();
         load_settings(s);
         no_idle = (p == 2);
         if (p == 3) hold_off_wanted = 1'b1;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            case ($urandom_range(0, 9))
               0:       el = '0;
               1:       el = '1;
               2, 3, 4: el = EL_W'($urandom_range(0, 2047));
               default: el = EL_W'($urandom);
            endcase
            send_step(el, $urandom_range(0, 9) == 0, $urandom_range(0, 7) == 0,
                      1'b0, '0);
         end
      end
      no_idle = 1'b0;

      // wind down with a bounded wait for the last results
      req_valid <= 1'b0;
      for (int n = 0; n < 2000 && pending_positions.size() != 0; n++) @(posedge clock);
      if (pending_positions.size() != 0)
         flag_error($sformatf("%0d results never arrived", pending_positions.size()));
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Run covered %0d steps and %0d checked results over %0d register sets,",
               steps_sent, results_checked, settings_loaded);
      $display("with saturation, frozen and restart steps, both rate signs and a long stall.");
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches", error_count);
         $display("Simulation FAILED");
      end
      $finish;
   end

   // hard stop
   initial begin
      #10_000_000;
      $display("Timeout with %0d results outstanding", pending_positions.size());
      $display("Simulation FAILED");
      $finish;
   end

endmodule

/* filelist.f */
design/eopg_pkg.sv
design/eopg_sine_unit.sv
design/elliptical_orbit_phase_generator.sv
verif/elliptical_orbit_phase_generator_tb.sv
